// ----- hdl/assert_macros.svh -----
// assertion macros used by the tracker rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define AST_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked outside reset
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- hdl/rtt_pkg.sv -----
// constants and widths for the round-trip timestamp tracker
package rtt_pkg;

    localparam int FRAC_BITS    = 8;
    localparam int RTT_INT_BITS = 14;
    localparam int RTT_W        = RTT_INT_BITS + FRAC_BITS;
    localparam int RQ_W         = 16 + FRAC_BITS;
    localparam int VAR_SUM_W    = RTT_W + 3;
    localparam int SRTT_SUM_W   = RTT_W + 4;
    localparam int RTO_SUM_W    = RTT_W + 3;
    localparam int RTO_RAW_W    = RTO_SUM_W - FRAC_BITS;

    localparam int TIME_W  = 64;
    localparam int SEQ_W   = 63;
    localparam int STAMP_W = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [STAMP_W-1:0] NO_STAMP = 16'hFFFF;

    localparam logic [RTT_W-1:0] RTT_MAX     = {RTT_W{1'b1}};
    localparam logic [RTT_W-1:0] SRTT_RESET  = RTT_W'(1000 * (2 ** FRAC_BITS));
    localparam logic [RTT_W-1:0] RTTVAR_RESET = RTT_W'(500 * (2 ** FRAC_BITS));
    localparam logic [RTO_SUM_W-1:0] RTO_ROUND = RTO_SUM_W'((2 ** FRAC_BITS) - 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RTO    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RTO    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_WIN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SAMPLE = 2'd3;

    localparam logic [CFG_W-1:0] MIN_RTO_RESET    = 16'd50;
    localparam logic [CFG_W-1:0] MAX_RTO_RESET    = 16'd1000;
    localparam logic [CFG_W-1:0] HOLD_WIN_RESET   = 16'd1000;
    localparam logic [CFG_W-1:0] MAX_SAMPLE_RESET = 16'd5000;

    // action codes
    localparam logic ACT_RECV = 1'b0;
    localparam logic ACT_SEND = 1'b1;

    // snapshot handed from the update stage to the timeout stage
    typedef struct packed {
        logic                   in_order;
        logic [STAMP_W-1:0]     out_stamp;
        logic [STAMP_W-1:0]     out_stamp_echo;
        logic [RTT_W-1:0]       srtt;
        logic [RTT_W-1:0]       rttvar;
    } t_upd;

endpackage

// ----- hdl/rtt_in_if.sv -----
// input channel: received header or send request
interface rtt_in_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [rtt_pkg::TIME_W-1:0]    now_ms;
    logic [rtt_pkg::SEQ_W-1:0]     seq_number;
    logic [rtt_pkg::STAMP_W-1:0]   peer_stamp;
    logic [rtt_pkg::STAMP_W-1:0]   peer_stamp_echo;

    modport source (
        output valid, action, now_ms, seq_number, peer_stamp, peer_stamp_echo,
        input  ready
    );
    modport sink (
        input  valid, action, now_ms, seq_number, peer_stamp, peer_stamp_echo,
        output ready
    );
endinterface

// ----- hdl/rtt_out_if.sv -----
// result channel: stamps and timeout estimates
interface rtt_out_if;
    logic                          valid;
    logic                          ready;
    logic                          in_order;
    logic [rtt_pkg::STAMP_W-1:0]   out_stamp;
    logic [rtt_pkg::STAMP_W-1:0]   out_stamp_echo;
    logic [rtt_pkg::STAMP_W-1:0]   rto_ms;
    logic [rtt_pkg::STAMP_W-1:0]   srtt_ms;

    modport source (
        output valid, in_order, out_stamp, out_stamp_echo, rto_ms, srtt_ms,
        input  ready
    );
    modport sink (
        input  valid, in_order, out_stamp, out_stamp_echo, rto_ms, srtt_ms,
        output ready
    );
endinterface

// ----- hdl/rtt_timestamp_tracker.sv -----
// round-trip timestamp tracker: sequence check, echo stamps, srtt/rttvar, rto
//
// Usage: i_item carries one item per valid/ready handshake, either a received
// packet header (action 0) or a request to build an outgoing header (action 1),
// each with the current time in ms. o_result returns exactly one item per input
// item, in order: in_order, out_stamp, out_stamp_echo, rto_ms and srtt_ms.
// Configuration registers (min/max rto, hold window, sample limit) are written
// through i_cfg_we/i_cfg_idx/i_cfg_data while no item is in flight.
// Pipeline: input register, update stage (sequence check, echo, estimator, all
// state written together), then the timeout stage (round up, clamp) into the
// result register. o_result.valid rises once the item has moved from the input
// register through the update stage register into the result register.
// Throughput is one item per cycle while o_result.ready is high; the state update
// at input-register exit lets every item see the state left by the one before it.
// A stalled o_result.ready holds the result register; the stages behind it fill
// and i_item.ready drops only when all three are occupied.
// Reset (i_rst_n low, synchronous) empties the pipeline and restores the
// estimator to srtt 1000 ms, rttvar 500 ms, no held stamp, expected sequence 0
// and the register defaults.
`include "assert_macros.svh"

module rtt_timestamp_tracker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rtt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rtt_pkg::CFG_W-1:0]     i_cfg_data,
    rtt_in_if.sink                        i_item,
    rtt_out_if.source                     o_result
);

    localparam int FB   = rtt_pkg::FRAC_BITS;
    localparam int W    = rtt_pkg::RTT_W;
    localparam int QW   = rtt_pkg::RQ_W;
    localparam int VSW  = rtt_pkg::VAR_SUM_W;
    localparam int SSW  = rtt_pkg::SRTT_SUM_W;
    localparam int RSW  = rtt_pkg::RTO_SUM_W;
    localparam int RRW  = rtt_pkg::RTO_RAW_W;
    localparam int TW   = rtt_pkg::TIME_W;
    localparam int SW   = rtt_pkg::SEQ_W;
    localparam int STW  = rtt_pkg::STAMP_W;

    // configuration
    logic [rtt_pkg::CFG_W-1:0] r_min_rto, r_max_rto, r_hold_win, r_max_sample;

    // connection state
    logic [SW-1:0]  r_exp_seq;
    logic [STW-1:0] r_held;
    logic [TW-1:0]  r_held_time;
    logic [W-1:0]   r_srtt, r_var;
    logic           r_have;

    // input register
    logic           r_a_valid;
    logic           r_a_action;
    logic [TW-1:0]  r_a_now;
    logic [SW-1:0]  r_a_seq;
    logic [STW-1:0] r_a_pstamp, r_a_pecho;

    // update stage register
    logic           r_b_valid;
    rtt_pkg::t_upd  r_b;

    // result register
    logic           r_c_valid;
    logic           r_c_in_order;
    logic [STW-1:0] r_c_stamp, r_c_echo, r_c_rto, r_c_srtt_ms;

    logic in_ready, a_adv, b_ready, b_adv, c_ready;

    assign c_ready  = !r_c_valid || o_result.ready;
    assign b_ready  = !r_b_valid || c_ready;
    assign b_adv    = r_b_valid && c_ready;
    assign a_adv    = r_a_valid && b_ready;
    assign in_ready = !r_a_valid || b_ready;

    assign i_item.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_rto    <= rtt_pkg::MIN_RTO_RESET;
            r_max_rto    <= rtt_pkg::MAX_RTO_RESET;
            r_hold_win   <= rtt_pkg::HOLD_WIN_RESET;
            r_max_sample <= rtt_pkg::MAX_SAMPLE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rtt_pkg::CFG_MIN_RTO:    r_min_rto    <= i_cfg_data;
                rtt_pkg::CFG_MAX_RTO:    r_max_rto    <= i_cfg_data;
                rtt_pkg::CFG_HOLD_WIN:   r_hold_win   <= i_cfg_data;
                rtt_pkg::CFG_MAX_SAMPLE: r_max_sample <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_ready) begin
            r_a_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_item.valid) begin
            r_a_action <= i_item.action;
            r_a_now    <= i_item.now_ms;
            r_a_seq    <= i_item.seq_number;
            r_a_pstamp <= i_item.peer_stamp;
            r_a_pecho  <= i_item.peer_stamp_echo;
        end
    end

    // update stage logic
    logic [STW-1:0] stamp_now, sample_r, echo_val;
    logic           rx_ok, take, echo_ok;
    logic [TW-1:0]  held_for;
    logic [QW-1:0]  rq, rq_half, srtt_q, diff;
    logic [VSW-1:0] var_sum;
    logic [SSW-1:0] srtt_sum;
    logic [W:0]     var_sh, srtt_sh;
    logic [W-1:0]   srtt_first, var_first, srtt_upd, var_upd;
    logic [W-1:0]   n_srtt, n_var;

    always_comb begin
        stamp_now = (r_a_now[STW-1:0] == rtt_pkg::NO_STAMP) ? '0 : r_a_now[STW-1:0];
        rx_ok     = (r_a_action == rtt_pkg::ACT_RECV) && (r_a_seq >= r_exp_seq);
        sample_r  = stamp_now - r_a_pecho;
        take      = rx_ok && (r_a_pecho != rtt_pkg::NO_STAMP) && (sample_r < r_max_sample);

        rq      = {sample_r, {FB{1'b0}}};
        rq_half = rq >> 1;
        srtt_q  = QW'(r_srtt);

        // first sample seeds the estimates
        srtt_first = (rq > QW'(rtt_pkg::RTT_MAX)) ? rtt_pkg::RTT_MAX : rq[W-1:0];
        var_first  = (rq_half > QW'(rtt_pkg::RTT_MAX)) ? rtt_pkg::RTT_MAX : rq_half[W-1:0];

        // rttvar = (3*rttvar + |srtt - rq|) / 4, srtt = (7*srtt + rq) / 8
        diff     = (srtt_q > rq) ? (srtt_q - rq) : (rq - srtt_q);
        var_sum  = VSW'(r_var) + VSW'({r_var, 1'b0}) + VSW'(diff);
        var_sh   = var_sum[VSW-1:2];
        var_upd  = var_sh[W] ? rtt_pkg::RTT_MAX : var_sh[W-1:0];
        srtt_sum = SSW'({r_srtt, 3'b000}) - SSW'(r_srtt) + SSW'(rq);
        srtt_sh  = srtt_sum[SSW-1:3];
        srtt_upd = srtt_sh[W] ? rtt_pkg::RTT_MAX : srtt_sh[W-1:0];

        n_srtt = r_srtt;
        n_var  = r_var;
        if (take) begin
            n_srtt = r_have ? srtt_upd : srtt_first;
            n_var  = r_have ? var_upd : var_first;
        end

        held_for = r_a_now - r_held_time;
        echo_ok  = (r_a_action == rtt_pkg::ACT_SEND) && (held_for < TW'(r_hold_win));
        echo_val = r_held + held_for[STW-1:0];
    end

    // connection state, written as the item leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_seq   <= '0;
            r_held      <= rtt_pkg::NO_STAMP;
            r_held_time <= '0;
            r_srtt      <= rtt_pkg::SRTT_RESET;
            r_var       <= rtt_pkg::RTTVAR_RESET;
            r_have      <= 1'b0;
        end else if (a_adv) begin
            r_srtt <= n_srtt;
            r_var  <= n_var;
            if (take) begin
                r_have <= 1'b1;
            end
            if (rx_ok) begin
                r_exp_seq <= r_a_seq + SW'(1);
                if (r_a_pstamp != rtt_pkg::NO_STAMP) begin
                    r_held      <= r_a_pstamp;
                    r_held_time <= r_a_now;
                end
            end else if (echo_ok) begin
                r_held      <= rtt_pkg::NO_STAMP;
                r_held_time <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_b.in_order       <= rx_ok;
            r_b.out_stamp      <= (r_a_action == rtt_pkg::ACT_SEND) ? stamp_now : '0;
            r_b.out_stamp_echo <= echo_ok ? echo_val : rtt_pkg::NO_STAMP;
            r_b.srtt           <= n_srtt;
            r_b.rttvar         <= n_var;
        end
    end

    // timeout stage: round up srtt + 4*rttvar, then clamp
    logic [RSW-1:0] rto_sum;
    logic [RRW-1:0] rto_raw;
    logic [STW-1:0] rto;

    always_comb begin
        rto_sum = RSW'(r_b.srtt) + RSW'({r_b.rttvar, 2'b00}) + rtt_pkg::RTO_ROUND;
        rto_raw = rto_sum[RSW-1:FB];
        if (rto_raw < RRW'(r_min_rto)) begin
            rto = r_min_rto;
        end else if (rto_raw > RRW'(r_max_rto)) begin
            rto = r_max_rto;
        end else begin
            rto = rto_raw[STW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (c_ready) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_c_in_order <= r_b.in_order;
            r_c_stamp    <= r_b.out_stamp;
            r_c_echo     <= r_b.out_stamp_echo;
            r_c_rto      <= rto;
            r_c_srtt_ms  <= STW'(r_b.srtt[W-1:FB]);
        end
    end

    assign o_result.valid          = r_c_valid;
    assign o_result.in_order       = r_c_in_order;
    assign o_result.out_stamp      = r_c_stamp;
    assign o_result.out_stamp_echo = r_c_echo;
    assign o_result.rto_ms         = r_c_rto;
    assign o_result.srtt_ms        = r_c_srtt_ms;

    // an empty held slot always has a zero hold time
    `AST_IMPL(a_held_empty, i_clk, i_rst_n, r_held == rtt_pkg::NO_STAMP, r_held_time == '0)
    // once seeded, the estimator never returns to the unseeded state
    `AST_NEXT(a_have_sticky, i_clk, i_rst_n, r_have, r_have)
    // a send item never moves the expected sequence number
    `AST_NEXT(a_send_keeps_seq, i_clk, i_rst_n, a_adv && r_a_action == rtt_pkg::ACT_SEND,
        $stable(r_exp_seq))
    // a stalled result is never dropped
    `AST_NEXT(a_result_kept, i_clk, i_rst_n, r_c_valid && !o_result.ready, r_c_valid)

endmodule
